FILE: rtl/core/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg: shared types and constants for the timestamp descending sorter
// Field widths, default capacity and the scan control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tds_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int TAG_W           = 16;
    localparam int KEY_W           = 64;
    localparam int ENTRY_W         = TAG_W + KEY_W;

    // control from the sequencer to the max-search unit
    typedef struct packed {
        logic start;      // begin a new search pass, forget current best
        logic cmp_vld;    // read data from the store is valid this cycle
        logic mark;       // current best was delivered, retire it
        logic clear_done; // run finished, forget all retired entries
    } t_scan_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/timestamp_descending_sorter_top.sv
// ----------------------------------------------------------------------------
// timestamp_descending_sorter_top: stable descending sort of a run by stamp
// Entries load one per cycle into the store while o_in_stall is low. After
// the final entry, each of the n results costs a full pass over the store
// through the RAM read port plus an output step; input is stalled until the
// run is out.
// Reset clears the fill count, overflow flag and last-delivered marker; store
// contents are left as is and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_descending_sorter_top #(
    parameter int MAX_ENTRIES = tds_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic        [tds_pkg::TAG_W-1:0]   i_entry_tag,
    input  wire logic signed [tds_pkg::KEY_W-1:0]   i_stamp,
    input  wire logic                               i_final_entry,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic             [tds_pkg::TAG_W-1:0]   o_sorted_tag,
    output logic signed      [tds_pkg::KEY_W-1:0]   o_sorted_stamp,
    output logic                                    o_run_end,
    output logic                                    o_dropped
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_fill, n_fill;
    logic               r_ovf, n_ovf;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [AW-1:0]      r_cmp_idx, n_cmp_idx;
    logic [CW-1:0]      r_remain, n_remain;

    logic               in_acc;
    logic               out_acc;
    logic               wr_en;
    tds_pkg::t_scan_ctl scan_ctl;
    logic [tds_pkg::ENTRY_W-1:0] rd_data;
    logic [tds_pkg::TAG_W-1:0]   best_tag;
    logic [tds_pkg::KEY_W-1:0]   best_key;

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign wr_en       = in_acc && (r_fill < CW'(MAX_ENTRIES));

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ovf     = r_ovf;
        n_rd_idx  = r_rd_idx;
        n_rd_vld  = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_remain  = r_remain;
        scan_ctl  = '0;
        scan_ctl.cmp_vld = r_rd_vld;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (wr_en) begin
                        n_fill = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_final_entry) begin
                        n_state        = S_SCAN;
                        n_rd_idx       = '0;
                        n_remain       = n_fill;
                        scan_ctl.start = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_idx < r_fill) begin
                    n_rd_vld  = 1'b1;
                    n_cmp_idx = r_rd_idx[AW-1:0];
                    n_rd_idx  = r_rd_idx + CW'(1);
                end else if (!r_rd_vld) begin
                    // last compare has landed in the search unit
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    scan_ctl.mark = 1'b1;
                    if (r_remain == CW'(1)) begin
                        n_state             = S_LOAD;
                        n_fill              = '0;
                        n_ovf               = 1'b0;
                        scan_ctl.clear_done = 1'b1;
                    end else begin
                        n_state        = S_SCAN;
                        n_remain       = r_remain - CW'(1);
                        n_rd_idx       = '0;
                        scan_ctl.start = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovf    <= n_ovf;
            r_rd_idx <= n_rd_idx;
            r_rd_vld <= n_rd_vld;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
    end

    tds_ram #(
        .WIDTH (tds_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data ({i_entry_tag, i_stamp}),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    tds_scan #(
        .AW          (AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_cmp_idx  (r_cmp_idx),
        .i_rd_tag   (rd_data[tds_pkg::ENTRY_W-1:tds_pkg::KEY_W]),
        .i_rd_key   (rd_data[tds_pkg::KEY_W-1:0]),
        .o_best_tag (best_tag),
        .o_best_key (best_key)
    );

    assign o_sorted_tag   = best_tag;
    assign o_sorted_stamp = best_key;
    assign o_run_end      = (r_remain == CW'(1));
    assign o_dropped      = r_ovf;

endmodule

`default_nettype wire

FILE: rtl/core/tds_ram.sv
// ----------------------------------------------------------------------------
// tds_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/tds_scan.sv
// ----------------------------------------------------------------------------
// tds_scan: max-search unit over the entry store
// Keeps the newest entry seen in the current pass among those that sort after
// the last delivered one (key descending, then slot ascending). Strict compare
// keeps the earliest on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module tds_scan #(
    parameter int AW = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tds_pkg::t_scan_ctl            i_ctl,
    input  wire logic [AW-1:0]                 i_cmp_idx,
    input  wire logic [tds_pkg::TAG_W-1:0]     i_rd_tag,
    input  wire logic [tds_pkg::KEY_W-1:0]     i_rd_key,
    output logic      [tds_pkg::TAG_W-1:0]     o_best_tag,
    output logic      [tds_pkg::KEY_W-1:0]     o_best_key
);

    logic                          r_have_last;
    logic [tds_pkg::KEY_W-1:0]     r_last_key;
    logic [AW-1:0]                 r_last_idx;
    logic                          r_have;
    logic [tds_pkg::KEY_W-1:0]     r_best_key;
    logic [tds_pkg::TAG_W-1:0]     r_best_tag;
    logic [AW-1:0]                 r_best_idx;
    logic                          eligible;
    logic                          take;

    // not yet delivered: sorts strictly after the last delivered entry
    assign eligible = !r_have_last ||
                      ($signed(i_rd_key) < $signed(r_last_key)) ||
                      ((i_rd_key == r_last_key) && (i_cmp_idx > r_last_idx));

    assign take = i_ctl.cmp_vld && eligible &&
                  (!r_have || ($signed(i_rd_key) > $signed(r_best_key)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            if (i_ctl.clear_done) begin
                r_have_last <= 1'b0;
            end else if (i_ctl.mark) begin
                r_have_last <= 1'b1;
            end
            if (i_ctl.start) begin
                r_have <= 1'b0;
            end else if (take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_key <= i_rd_key;
            r_best_tag <= i_rd_tag;
            r_best_idx <= i_cmp_idx;
        end
        if (i_ctl.mark) begin
            r_last_key <= r_best_key;
            r_last_idx <= r_best_idx;
        end
    end

    assign o_best_tag = r_best_tag;
    assign o_best_key = r_best_key;

endmodule

`default_nettype wire
